// ===== rtl/sers_pkg.sv =====
// Shared constants and types for the sparse entry row-major sorter.
// No dependencies; compiled first.
package sers_pkg;

  localparam int MAX_ENTRIES_DEF   = 64;
  localparam int INDEX_WIDTH_DEF   = 16;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  // Sequencer to min-scan unit control
  typedef struct packed {
    logic clear;   // drop the current best, a new pass begins
    logic sample;  // a candidate entry is presented this cycle
  } sers_scan_ctrl_t;

endpackage : sers_pkg

// ===== rtl/sers_if.sv =====
// Valid/ready channel interfaces for entry requests and sorted results.
// Depends on sers_pkg for default widths.
interface sers_in_if
  import sers_pkg::*;
#(
  parameter int INDEX_WIDTH   = INDEX_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic [INDEX_WIDTH-1:0]   row_index;
  logic [INDEX_WIDTH-1:0]   column_index;
  logic [PAYLOAD_WIDTH-1:0] payload;
  logic                     final_entry;

  modport source (output valid, row_index, column_index, payload, final_entry,
                  input  ready);
  modport sink   (input  valid, row_index, column_index, payload, final_entry,
                  output ready);
endinterface : sers_in_if

interface sers_out_if
  import sers_pkg::*;
#(
  parameter int INDEX_WIDTH   = INDEX_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic [INDEX_WIDTH-1:0]   sorted_row;
  logic [INDEX_WIDTH-1:0]   sorted_column;
  logic [PAYLOAD_WIDTH-1:0] sorted_payload;
  logic                     end_of_run;
  logic                     overflowed;

  modport source (output valid, sorted_row, sorted_column, sorted_payload,
                         end_of_run, overflowed,
                  input  ready);
  modport sink   (input  valid, sorted_row, sorted_column, sorted_payload,
                         end_of_run, overflowed,
                  output ready);
endinterface : sers_out_if

// ===== rtl/sers_min_scan.sv =====
// Shared compare unit: tracks the smallest (row, column) entry of one scan pass.
// Depends on sers_pkg. Earlier samples win ties, which keeps the sort stable.
module sers_min_scan
  import sers_pkg::*;
#(
  parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF,
  parameter int INDEX_WIDTH   = INDEX_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sers_scan_ctrl_t                        ctrl,
  input  logic [$clog2(MAX_ENTRIES)-1:0]         sample_idx,
  input  logic [2*INDEX_WIDTH+PAYLOAD_WIDTH-1:0] sample_entry,
  output logic                                   best_vld,
  output logic [$clog2(MAX_ENTRIES)-1:0]         best_idx,
  output logic [2*INDEX_WIDTH+PAYLOAD_WIDTH-1:0] best_entry
);

  localparam int AW      = $clog2(MAX_ENTRIES);
  localparam int KEY_W   = 2 * INDEX_WIDTH;
  localparam int ENTRY_W = KEY_W + PAYLOAD_WIDTH;

  logic                best_vld_r;
  logic [AW-1:0]       best_idx_r;
  logic [ENTRY_W-1:0]  best_entry_r;
  logic                take;

  // entry layout {row, column, payload}: the key compare is one wide compare
  assign take = ctrl.sample &&
                (!best_vld_r ||
                 (sample_entry[ENTRY_W-1 -: KEY_W] < best_entry_r[ENTRY_W-1 -: KEY_W]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
    end else if (ctrl.clear) begin
      best_vld_r <= 1'b0;
    end else if (take) begin
      best_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !ctrl.clear) begin
      best_idx_r   <= sample_idx;
      best_entry_r <= sample_entry;
    end
  end

  assign best_vld   = best_vld_r;
  assign best_idx   = best_idx_r;
  assign best_entry = best_entry_r;

endmodule : sers_min_scan

// ===== rtl/sparse_entry_row_major_sort_core.sv =====
// Top level of the sparse entry row-major sorter: entry store, sequencer, output register.
// Depends on sers_pkg, sers_in_if / sers_out_if and sers_min_scan.
//
// Usage:
//  - in_chan takes one coordinate entry request (row, column, payload) per cycle
//    while the block is collecting. Up to MAX_ENTRIES entries are stored; further
//    entries are dropped and the set is flagged as overflowed.
//  - The request with final_entry set ends the set. in_chan.ready then stays low
//    until every stored entry has left on out_chan.
//  - out_chan returns the entries ascending by row, then column; equal keys leave
//    in arrival order. end_of_run marks the last one, overflowed is set on every
//    result of a set that lost entries.
//  - Each result needs one selection pass over the store, which reads the stored
//    entries one at a time through the single read port of the entry store feeding
//    the shared compare unit; the result then waits in the output register.
//    Collection is one request per cycle.
//  - A stalled receiver simply holds the result in the output register; the next
//    selection pass starts once it is taken.
//  - Synchronous active-low reset empties the store and the overflow flag; the
//    store contents themselves are not cleared (the fill count guards them).
module sparse_entry_row_major_sort_core
  import sers_pkg::*;
#(
  parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF,
  parameter int INDEX_WIDTH   = INDEX_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sers_in_if.sink   in_chan,
  sers_out_if.source out_chan
);

  localparam int AW      = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W   = 2 * INDEX_WIDTH;
  localparam int ENTRY_W = KEY_W + PAYLOAD_WIDTH;

  typedef enum logic [1:0] {
    S_LOAD,  // collecting entries
    S_SCAN,  // selection pass over the store
    S_EMIT   // result waits in output register
  } state_t;

  state_t                 state_r;
  logic [CNT_W-1:0]       count_r;      // stored entries
  logic                   ovf_r;        // entries dropped in this set
  logic [CNT_W-1:0]       emit_cnt_r;   // results already delivered
  logic [CNT_W-1:0]       scan_addr_r;  // read pointer of the pass
  logic                   rd_vld_r;
  logic [AW-1:0]          rd_idx_r;
  logic [ENTRY_W-1:0]     rd_data_r;
  logic [MAX_ENTRIES-1:0] taken_r;      // entries already emitted this set

  logic                   out_valid_r;
  logic                   out_last_r;
  logic                   out_ovf_r;
  logic [ENTRY_W-1:0]     out_entry_r;

  logic [ENTRY_W-1:0]     entry_mem [MAX_ENTRIES];

  logic                   in_fire;
  logic                   out_fire;
  logic                   has_room;
  logic                   scan_done;
  logic                   start_pass;
  sers_scan_ctrl_t        scan_ctrl;
  logic                   best_vld;
  logic [AW-1:0]          best_idx;
  logic [ENTRY_W-1:0]     best_entry;

  assign in_chan.ready = (state_r == S_LOAD);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_fire      = out_valid_r && out_chan.ready;
  assign has_room      = (count_r < CNT_W'(MAX_ENTRIES));
  assign scan_done     = (state_r == S_SCAN) && (scan_addr_r == count_r) && !rd_vld_r;

  // a new pass starts after the final request or after a non-last result leaves
  assign start_pass = (in_fire && in_chan.final_entry) || (out_fire && !out_last_r);

  assign scan_ctrl.clear  = start_pass;
  assign scan_ctrl.sample = (state_r == S_SCAN) && rd_vld_r && !taken_r[rd_idx_r];

  // Entry store: one write port (collection), one registered read port (scan)
  always_ff @(posedge clk) begin
    if (in_fire && has_room) begin
      entry_mem[count_r[AW-1:0]] <= {in_chan.row_index, in_chan.column_index,
                                     in_chan.payload};
    end
    rd_data_r <= entry_mem[scan_addr_r[AW-1:0]];
  end

  sers_min_scan #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .INDEX_WIDTH  (INDEX_WIDTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
  ) u_min_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (scan_ctrl),
    .sample_idx  (rd_idx_r),
    .sample_entry(rd_data_r),
    .best_vld    (best_vld),
    .best_idx    (best_idx),
    .best_entry  (best_entry)
  );

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      emit_cnt_r  <= '0;
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
      taken_r     <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_ovf_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          rd_vld_r <= 1'b0;
          if (in_fire) begin
            if (has_room) begin
              count_r <= count_r + CNT_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_chan.final_entry) begin
              state_r     <= S_SCAN;
              emit_cnt_r  <= '0;
              scan_addr_r <= '0;
              taken_r     <= '0;
            end
          end
        end
        S_SCAN: begin
          rd_vld_r <= (scan_addr_r < count_r);
          rd_idx_r <= scan_addr_r[AW-1:0];
          if (scan_addr_r < count_r) begin
            scan_addr_r <= scan_addr_r + CNT_W'(1);
          end
          if (scan_done) begin
            state_r           <= S_EMIT;
            taken_r[best_idx] <= 1'b1;
            out_valid_r       <= 1'b1;
            out_last_r        <= (CNT_W'(emit_cnt_r + CNT_W'(1)) == count_r);
            out_ovf_r         <= ovf_r;
          end
        end
        S_EMIT: begin
          rd_vld_r <= 1'b0;
          if (out_fire) begin
            out_valid_r <= 1'b0;
            emit_cnt_r  <= emit_cnt_r + CNT_W'(1);
            if (out_last_r) begin
              state_r <= S_LOAD;
              count_r <= '0;
              ovf_r   <= 1'b0;
            end else begin
              state_r     <= S_SCAN;
              scan_addr_r <= '0;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (scan_done) begin
      out_entry_r <= best_entry;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.sorted_row     = out_entry_r[ENTRY_W-1 -: INDEX_WIDTH];
  assign out_chan.sorted_column  = out_entry_r[PAYLOAD_WIDTH +: INDEX_WIDTH];
  assign out_chan.sorted_payload = out_entry_r[PAYLOAD_WIDTH-1:0];
  assign out_chan.end_of_run     = out_last_r;
  assign out_chan.overflowed     = out_ovf_r;

  // Fill count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  // During a pass, exactly the delivered entries are marked taken
  a_taken_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ($countones(taken_r) == int'(emit_cnt_r)))
    else $error("taken marks out of step with delivered results");

  // A finished pass always found an untaken entry
  a_pass_found: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> best_vld)
    else $error("selection pass ended without a candidate");

  // After the last result the store is empty and collection resumes
  a_set_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_r) |=> (count_r == '0) && !ovf_r && (state_r == S_LOAD))
    else $error("set not closed after last result");

endmodule : sparse_entry_row_major_sort_core
